/* sv/rgc_pkg.sv */
// Shared constants, codes and pipeline item types for the RGB gain clamp.
// Depends on nothing; every other file uses it.
package rgc_pkg;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int CH_W           = 8;
    localparam int GAIN_W         = 16;
    localparam int PROD_W         = CH_W + GAIN_W;
    localparam int NUM_W          = 2 * CH_W;
    localparam int N_CH           = 3;
    localparam int STEP_BITS      = 2;
    localparam int DIV_STEPS      = CH_W / STEP_BITS;
    localparam int STEP_IDX_W     = $clog2(CH_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;
    localparam int MODE_W     = 2;

    localparam logic [CH_W-1:0]   CH_MAX      = {CH_W{1'b1}};
    localparam logic [PROD_W-1:0] CLAMP_LIMIT = PROD_W'(CH_MAX) << GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(1) << GAIN_FRAC_BITS;

    // pixel_mode codes; the fourth code passes through like MODE_PASS
    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGBX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_RGB;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;

    typedef logic [N_CH-1:0][CH_W-1:0] t_chans;

    // after the gain multiply
    typedef struct packed {
        logic                          scale;
        t_chans                        ch;
        logic [N_CH-1:0][PROD_W-1:0]   prod;
        logic [CH_W-1:0]               cmax;
        logic [CH_W-1:0]               extra;
        logic                          last;
    } t_prod_item;

    // clamp decision made, ratio divide in flight
    typedef struct packed {
        logic                          scale;
        logic                          over;
        t_chans                        ch;
        t_chans                        lin;
        logic [N_CH-1:0][NUM_W-1:0]    rem;
        t_chans                        quo;
        logic [CH_W-1:0]               div;
        logic [CH_W-1:0]               extra;
        logic                          last;
    } t_work;

endpackage

/* sv/rgc_if.sv */
// Channel interfaces: pixel in, pixel out and configuration writes.
// Depends on rgc_pkg.
interface rgc_pix_in_if;
    logic                    valid;
    logic                    ready;
    logic [rgc_pkg::CH_W-1:0] red_in;
    logic [rgc_pkg::CH_W-1:0] green_in;
    logic [rgc_pkg::CH_W-1:0] blue_in;
    logic [rgc_pkg::CH_W-1:0] extra_in;
    logic                    last_in;

    modport source (output valid, red_in, green_in, blue_in, extra_in, last_in,
                    input ready);
    modport sink   (input valid, red_in, green_in, blue_in, extra_in, last_in,
                    output ready);
endinterface

interface rgc_pix_out_if;
    logic                    valid;
    logic                    ready;
    logic [rgc_pkg::CH_W-1:0] red_out;
    logic [rgc_pkg::CH_W-1:0] green_out;
    logic [rgc_pkg::CH_W-1:0] blue_out;
    logic [rgc_pkg::CH_W-1:0] extra_out;
    logic                    last_out;

    modport source (output valid, red_out, green_out, blue_out, extra_out, last_out,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, extra_out, last_out,
                    output ready);
endinterface

interface rgc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rgc_pkg::CFG_IDX_W-1:0]  index;
    logic [rgc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/rgb_gain_ratio_clamp.sv */
// RGB gain with ratio-preserving clamp, top level.
// Registered stages: multiply, clamp test, then four divide stages that retire
// two quotient bits each. Throughput: one pixel per cycle while the output is
// ready; each stage holds its item on a stall. Reset (sync, active low) empties
// the pipeline and sets gain to unity, pixel mode to three-byte pixels.
// Depends on rgc_pkg, rgc_if and stages.
module rgb_gain_ratio_clamp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgc_cfg_if.sink       i_cfg,
    rgc_pix_in_if.sink    i_pix,
    rgc_pix_out_if.source o_pix
);
    import rgc_pkg::*;

    // The user must write configuration only while the pipeline is empty; the block
    // does not enforce this. So every stage may read the live registers.
    logic [GAIN_W-1:0] gain;
    logic [MODE_W-1:0] mode;

    rgc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_gain  (gain),
        .o_mode  (mode)
    );

    // Stage 1: products c * gain and the largest input channel.
    t_chans     in_ch;
    logic       s1_valid;
    logic       s1_ready;
    t_prod_item s1_item;

    assign in_ch[0] = i_pix.red_in;
    assign in_ch[1] = i_pix.green_in;
    assign in_ch[2] = i_pix.blue_in;

    rgc_gain_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_ch    (in_ch),
        .i_extra (i_pix.extra_in),
        .i_last  (i_pix.last_in),
        .i_gain  (gain),
        .i_mode  (mode),
        .o_ready (i_pix.ready),
        .o_valid (s1_valid),
        .o_item  (s1_item),
        .i_ready (s1_ready)
    );

    // Stage 2: clamp decision. When the largest product passes 255.0 the
    // result is floor(c * 255 / cmax), since the gain divides out.
    logic  dv_valid [DIV_STEPS+1];
    logic  dv_ready [DIV_STEPS+1];
    t_work dv_item  [DIV_STEPS+1];

    rgc_clamp_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_item  (s1_item),
        .o_ready (s1_ready),
        .o_valid (dv_valid[0]),
        .o_item  (dv_item[0]),
        .i_ready (dv_ready[0])
    );

    // Stages 3 to 6: quotient bits from the top down, two per stage.
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        rgc_div_step u_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_top_bit (STEP_IDX_W'(CH_W - 1 - STEP_BITS * s)),
            .i_valid   (dv_valid[s]),
            .i_item    (dv_item[s]),
            .o_ready   (dv_ready[s]),
            .o_valid   (dv_valid[s+1]),
            .o_item    (dv_item[s+1]),
            .i_ready   (dv_ready[s+1])
        );
    end

    // Result select: pass-through modes keep the input bytes, otherwise the
    // clamped ratio or the plain truncated product.
    t_work  fin;
    t_chans res;

    assign fin = dv_item[DIV_STEPS];

    always_comb begin
        for (int k = 0; k < N_CH; k++) begin
            if (!fin.scale) begin
                res[k] = fin.ch[k];
            end else if (fin.over) begin
                res[k] = fin.quo[k];
            end else begin
                res[k] = fin.lin[k];
            end
        end
    end

    assign dv_ready[DIV_STEPS] = o_pix.ready;
    assign o_pix.valid     = dv_valid[DIV_STEPS];
    assign o_pix.red_out   = res[0];
    assign o_pix.green_out = res[1];
    assign o_pix.blue_out  = res[2];
    assign o_pix.extra_out = fin.extra;
    assign o_pix.last_out  = fin.last;

    // Reset empties the pipeline by the next edge.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_pix.valid)
        else $error("result valid right after reset");

    // The clamp path only ever comes from a scaling mode with a live divisor.
    a_over_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && fin.over |-> fin.scale && (fin.div != '0))
        else $error("clamp with zero divisor or in pass-through mode");

    // With clamping, the brightest channel lands exactly on full scale.
    a_over_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && fin.over |->
            (fin.quo[0] == CH_MAX) || (fin.quo[1] == CH_MAX) || (fin.quo[2] == CH_MAX))
        else $error("clamped pixel has no channel at full scale");

endmodule

/* sv/rgc_cfg_regs.sv */
// Configuration registers: gain and pixel mode.
// Depends on rgc_pkg.
module rgc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rgc_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [rgc_pkg::CFG_DATA_W-1:0] i_data,
    output logic                          o_ready,
    output logic [rgc_pkg::GAIN_W-1:0]     o_gain,
    output logic [rgc_pkg::MODE_W-1:0]     o_mode
);
    import rgc_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    logic [MODE_W-1:0] r_mode;

    assign o_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_mode <= MODE_RESET;
        end else if (i_valid) begin
            case (i_index)
                REG_GAIN: r_gain <= i_data[GAIN_W-1:0];
                REG_MODE: r_mode <= i_data[MODE_W-1:0];
                default:  ;   // unknown index, dropped
            endcase
        end
    end

    assign o_gain = r_gain;
    assign o_mode = r_mode;

endmodule

/* sv/rgc_gain_mul.sv */
// Stage 1: per-channel gain products, channel maximum, mode decode.
// Depends on rgc_pkg.
module rgc_gain_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  rgc_pkg::t_chans            i_ch,
    input  logic [rgc_pkg::CH_W-1:0]   i_extra,
    input  logic                       i_last,
    input  logic [rgc_pkg::GAIN_W-1:0] i_gain,
    input  logic [rgc_pkg::MODE_W-1:0] i_mode,
    output logic                       o_ready,
    output logic                       o_valid,
    output rgc_pkg::t_prod_item        o_item,
    input  logic                       i_ready
);
    import rgc_pkg::*;

    logic       r_valid;
    t_prod_item r_item;
    t_prod_item n_item;

    always_comb begin
        n_item.scale = (i_mode == MODE_RGB) || (i_mode == MODE_RGBX);
        n_item.ch    = i_ch;
        n_item.last  = i_last;
        n_item.extra = (i_mode == MODE_RGB) ? '0 : i_extra;
        for (int k = 0; k < N_CH; k++) begin
            n_item.prod[k] = PROD_W'(i_ch[k]) * PROD_W'(i_gain);
        end
        n_item.cmax = i_ch[0];
        if (i_ch[1] > n_item.cmax) n_item.cmax = i_ch[1];
        if (i_ch[2] > n_item.cmax) n_item.cmax = i_ch[2];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* sv/rgc_clamp_sel.sv */
// Stage 2: overflow test on the largest product, linear result, divide setup.
// Depends on rgc_pkg.
module rgc_clamp_sel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rgc_pkg::t_prod_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    output rgc_pkg::t_work      o_item,
    input  logic                i_ready
);
    import rgc_pkg::*;

    logic              r_valid;
    t_work             r_item;
    t_work             n_item;
    logic [PROD_W-1:0] top;

    always_comb begin
        top = i_item.prod[0];
        if (i_item.prod[1] > top) top = i_item.prod[1];
        if (i_item.prod[2] > top) top = i_item.prod[2];

        n_item.scale = i_item.scale;
        n_item.over  = i_item.scale && (top > CLAMP_LIMIT);
        n_item.ch    = i_item.ch;
        n_item.div   = i_item.cmax;
        n_item.extra = i_item.extra;
        n_item.last  = i_item.last;
        n_item.quo   = '0;
        for (int k = 0; k < N_CH; k++) begin
            n_item.lin[k] = i_item.prod[k][GAIN_FRAC_BITS +: CH_W];
            // c * 255; gain cancels out of p * 255 / max(p)
            n_item.rem[k] = (NUM_W'(i_item.ch[k]) << CH_W) - NUM_W'(i_item.ch[k]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* sv/rgc_div_step.sv */
// Divide stage: retires STEP_BITS quotient bits per lane, restoring form.
// Depends on rgc_pkg.
module rgc_div_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rgc_pkg::STEP_IDX_W-1:0] i_top_bit,
    input  logic                           i_valid,
    input  rgc_pkg::t_work                 i_item,
    output logic                           o_ready,
    output logic                           o_valid,
    output rgc_pkg::t_work                 o_item,
    input  logic                           i_ready
);
    import rgc_pkg::*;

    logic                  r_valid;
    t_work                 r_item;
    t_work                 n_item;
    logic [STEP_IDX_W-1:0] bit_pos;
    logic [NUM_W-1:0]      shifted;

    always_comb begin
        n_item  = i_item;
        bit_pos = '0;
        shifted = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
            bit_pos = i_top_bit - STEP_IDX_W'(j);
            shifted = NUM_W'(i_item.div) << bit_pos;
            for (int k = 0; k < N_CH; k++) begin
                if (n_item.rem[k] >= shifted) begin
                    n_item.rem[k]          = n_item.rem[k] - shifted;
                    n_item.quo[k][bit_pos] = 1'b1;
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
